@@ hw/rtl/supi_pkg.sv @@
// ----------------------------------------------------------------------------
// supi_pkg
// Shared types and constants for the sorted unique position table.
// ----------------------------------------------------------------------------
package supi_pkg;

  localparam int unsigned LineW   = 16;
  localparam int unsigned OrderW  = 8;
  localparam int unsigned SentW   = 16;
  localparam int unsigned KeyW    = LineW + OrderW + SentW;
  localparam int unsigned StatusW = 2;
  localparam int unsigned AtW     = 6;
  localparam int unsigned CountW  = 7;

  typedef logic [KeyW-1:0] key_t;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // per-cell compare result against the broadcast key
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

@@ hw/rtl/supi_if.sv @@
// ----------------------------------------------------------------------------
// supi_in_if / supi_out_if
// Valid/ready channels for the position words and the insert results.
// ----------------------------------------------------------------------------
interface supi_in_if;
  import supi_pkg::*;

  logic              valid;
  logic              ready;
  logic [LineW-1:0]  line_number;
  logic [OrderW-1:0] word_order;
  logic [SentW-1:0]  sentence_number;

  modport source (output valid, output line_number, output word_order,
                  output sentence_number, input ready);
  modport sink   (input valid, input line_number, input word_order,
                  input sentence_number, output ready);
endinterface

interface supi_out_if;
  import supi_pkg::*;

  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [AtW-1:0]     inserted_at;
  logic [CountW-1:0]  entry_count;

  modport source (output valid, output status, output inserted_at,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input inserted_at,
                  input entry_count, output ready);
endinterface

@@ hw/rtl/supi_cell.sv @@
// ----------------------------------------------------------------------------
// supi_cell
// One slot of the sorted table: compares its key with the broadcast key and
// on an insert either keeps its key, takes the new key or takes its lower
// neighbour's key.
// ----------------------------------------------------------------------------
module supi_cell #(
  parameter int unsigned CntW = 7,
  parameter int unsigned Idx  = 0
) (
  input  logic                  clk_i,
  input  supi_pkg::key_t        key_i,
  input  supi_pkg::key_t        prev_key_i,
  input  logic                  prev_lt_i,
  input  logic [CntW-1:0]       count_i,
  input  logic                  ins_i,
  output supi_pkg::key_t        key_o,
  output supi_pkg::cell_flags_t flags_o
);
  import supi_pkg::*;

  key_t key_q, key_d;
  logic occ;

  assign occ        = CntW'(Idx) < count_i;
  assign flags_o.lt = occ && (key_q < key_i);
  assign flags_o.eq = occ && (key_q == key_i);
  assign key_o      = key_q;

  always_comb begin
    key_d = key_q;
    if (ins_i && !flags_o.lt) begin
      key_d = prev_lt_i ? key_i : prev_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

@@ hw/rtl/sorted_unique_position_insert_top.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_position_insert_top
// Sorted table of word positions, kept unique, built as a row of cells.
//
// in_i carries one position word (line, word order, sentence); out_o returns
// one result word per position: status, slot placed or found, and the entry
// count after the word. Keys order by line, then word order, then sentence.
// Every cell compares the broadcast key in the accept cycle and shifts up by
// one slot in the same edge, so the result is registered in the cycle after
// accept and a new position is taken every cycle while out_o is not stalled.
// The cell compare and the slot encoder over CAPACITY cells set the cycle.
// A duplicate returns the slot of the match; a new key into a full table
// returns the full status and slot 0. Neither changes the table.
// Reset empties the table (count zero) and drops any pending result.
// While out_o is stalled the result is held and in_i is taken only in the
// cycle the held result leaves.
// ----------------------------------------------------------------------------
module sorted_unique_position_insert_top #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  supi_in_if.sink     in_i,
  supi_out_if.source  out_o
);
  import supi_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  key_t        key;
  key_t        cell_key [CAPACITY];
  cell_flags_t flags    [CAPACITY];
  logic [CAPACITY-1:0] lt_vec, eq_vec, bnd_vec;

  logic [CW-1:0] count_q, count_d;
  logic          accept, dup, full, ins;
  logic [IW-1:0] pos;
  logic [IW+AtW-1:0]    at_wide;
  logic [CW+CountW-1:0] cnt_wide;

  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [AtW-1:0]     at_q, at_d;
  logic [CountW-1:0]  cnt_q;

  assign key    = {in_i.line_number, in_i.word_order, in_i.sentence_number};
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t prev_key;
    logic prev_lt;
    if (i == 0) begin : g_head
      assign prev_key = key;
      assign prev_lt  = 1'b1;
    end else begin : g_body
      assign prev_key = cell_key[i-1];
      assign prev_lt  = flags[i-1].lt;
    end

    supi_cell #(.CntW(CW), .Idx(i)) u_cell (
      .clk_i      (clk_i),
      .key_i      (key),
      .prev_key_i (prev_key),
      .prev_lt_i  (prev_lt),
      .count_i    (count_q),
      .ins_i      (ins),
      .key_o      (cell_key[i]),
      .flags_o    (flags[i])
    );

    assign lt_vec[i]  = flags[i].lt;
    assign eq_vec[i]  = flags[i].eq;
    assign bnd_vec[i] = prev_lt && !flags[i].lt;
  end

  assign dup  = |eq_vec;
  assign full = count_q == CW'(CAPACITY);
  assign ins  = accept && !dup && !full;

  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd_vec[i]) pos = pos | IW'(i);
    end
  end

  always_comb begin
    count_d  = ins ? count_q + CW'(1) : count_q;
    status_d = ST_INSERTED;
    at_wide  = {{AtW{1'b0}}, pos};
    if (dup) begin
      status_d = ST_DUPLICATE;
    end else if (full) begin
      status_d = ST_FULL;
      at_wide  = '0;
    end
    at_d     = at_wide[AtW-1:0];
    cnt_wide = {{CountW{1'b0}}, count_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      at_q     <= at_d;
      cnt_q    <= cnt_wide[CountW-1:0];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.inserted_at = at_q;
  assign out_o.entry_count = cnt_q;

  // sanity checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(bnd_vec) && $onehot0(eq_vec))
    else $error("more than one insert slot or match");

  a_dup_at_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dup |-> ((eq_vec & bnd_vec) == eq_vec))
    else $error("match not at the insert slot");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins |=> count_q == $past(count_q) + CW'(1))
    else $error("count did not grow on insert");

  a_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((lt_vec & (lt_vec + CAPACITY'(1))) == '0))
    else $error("stored keys out of order");

endmodule

@@ sim/sorted_unique_position_insert_top_test.sv @@
// ----------------------------------------------------------------------------
// sorted_unique_position_insert_top_test
// Self-checking bench for the sorted unique position table.
//
// Position words go in through a queued driver with random gaps. Each
// accepted word updates a shadow copy of the table, which predicts the
// status, slot and entry count. A monitor with random back-pressure checks
// every result word against the oldest prediction. The table is filled,
// then hit with duplicates and rejected inserts while full.
// ----------------------------------------------------------------------------
module sorted_unique_position_insert_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import supi_pkg::*;

  localparam int unsigned Capacity   = 64;
  localparam int unsigned RandWords  = 1900;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    logic [LineW-1:0]  line;
    logic [OrderW-1:0] order;
    logic [SentW-1:0]  sent;
    int unsigned       gap;
    bit                drain;
  } position_word_t;

  typedef struct packed {
    status_e           status;
    logic [AtW-1:0]    slot;
    logic [CountW-1:0] count;
  } insert_result_t;

  logic clk;
  logic rst_n;

  supi_in_if  in_if ();
  supi_out_if out_if ();

  sorted_unique_position_insert_top #(
    .CAPACITY(Capacity)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  position_word_t  words_to_send[$];
  key_t            offered_keys[$];
  insert_result_t  expected_results[$];
  key_t            shadow_keys[Capacity];
  int unsigned     shadow_count;

  int unsigned errors;
  int unsigned words_accepted;
  int unsigned results_checked;
  int unsigned n_inserted, n_duplicate, n_full;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void queue_word(input logic [LineW-1:0] line,
                                     input logic [OrderW-1:0] order,
                                     input logic [SentW-1:0] sent,
                                     input bit drain);
    position_word_t w;
    w.line  = line;
    w.order = order;
    w.sent  = sent;
    // every third stretch of 120 words runs back to back
    w.gap   = ((words_to_send.size() / 120) % 3 == 2) ? 0 : $urandom_range(0, 5);
    w.drain = drain;
    words_to_send.push_back(w);
    offered_keys.push_back({line, order, sent});
  endfunction

  function automatic void predict_insert(input key_t key);
    insert_result_t r;
    int unsigned    below;
    below = 0;
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] < key) below++;
    end
    if (below < shadow_count && shadow_keys[below] == key) begin
      r.status = ST_DUPLICATE;
      r.slot   = below[AtW-1:0];
    end else if (shadow_count >= Capacity) begin
      r.status = ST_FULL;
      r.slot   = '0;
    end else begin
      for (int unsigned i = shadow_count; i > below; i--) begin
        shadow_keys[i] = shadow_keys[i-1];
      end
      shadow_keys[below] = key;
      shadow_count++;
      r.status = ST_INSERTED;
      r.slot   = below[AtW-1:0];
    end
    r.count = shadow_count[CountW-1:0];
    expected_results.push_back(r);
  endfunction

  function automatic logic [LineW-1:0] draw_line();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return LineW'(16'h7FFE + $urandom_range(0, 3));
      default: return LineW'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [OrderW-1:0] draw_order();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return OrderW'(8'h7E + $urandom_range(0, 3));
      default: return OrderW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [SentW-1:0] draw_sent();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return SentW'(16'h7FFE + $urandom_range(0, 3));
      default: return SentW'($urandom_range(0, 65535));
    endcase
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    bit          take;
    bit          nxt_valid;
    static int unsigned gap_left  = 0;
    static bit          gap_armed = 1'b0;
    if (!rst_n) begin
      in_if.valid           <= 1'b0;
      in_if.line_number     <= '0;
      in_if.word_order      <= '0;
      in_if.sentence_number <= '0;
      gap_left  = 0;
      gap_armed = 1'b0;
    end else begin
      take = in_if.valid && in_if.ready;
      if (take) begin
        predict_insert({in_if.line_number, in_if.word_order, in_if.sentence_number});
        void'(words_to_send.pop_front());
        words_accepted++;
        gap_armed = 1'b0;
      end
      if (take || !in_if.valid) begin
        nxt_valid = 1'b0;
        if (words_to_send.size() > 0) begin
          if (!gap_armed) begin
            gap_left  = words_to_send[0].gap;
            gap_armed = 1'b1;
          end
          if (gap_left > 0) begin
            gap_left--;
          end else if (!words_to_send[0].drain || expected_results.size() == 0) begin
            nxt_valid = 1'b1;
            in_if.line_number     <= words_to_send[0].line;
            in_if.word_order      <= words_to_send[0].order;
            in_if.sentence_number <= words_to_send[0].sent;
          end
        end
        in_if.valid <= nxt_valid;
      end
    end
  end

  // monitor
  always @(posedge clk or negedge rst_n) begin
    insert_result_t exp_r;
    static int unsigned wait_left = 0;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      wait_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no expectation: status %0d slot %0d count %0d",
                 out_if.status, out_if.inserted_at, out_if.entry_count);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_if.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_if.status);
            errors++;
          end
          if (out_if.inserted_at !== exp_r.slot) begin
            $error("inserted_at: expected %0d, got %0d", exp_r.slot, out_if.inserted_at);
            errors++;
          end
          if (out_if.entry_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, out_if.entry_count);
            errors++;
          end
          case (exp_r.status)
            ST_INSERTED:  n_inserted++;
            ST_DUPLICATE: n_duplicate++;
            default:      n_full++;
          endcase
        end
        results_checked++;
        if (results_checked % 500 == 250) wait_left = 80;
        else if ((results_checked / 150) % 3 == 1) wait_left = 0;
        else wait_left = $urandom_range(0, 5);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_if.ready <= (wait_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    key_t k;
    rst_n = 1'b0;
    shadow_count = 0;

    // empty table: middle, ahead of head, tail, then duplicates of each
    queue_word(16'h8000, 8'h80, 16'h8000, 1'b0);
    queue_word(16'h0000, 8'h00, 16'h0000, 1'b0);
    queue_word(16'hFFFF, 8'hFF, 16'hFFFF, 1'b0);
    queue_word(16'h0000, 8'h00, 16'h0000, 1'b0);
    queue_word(16'hFFFF, 8'hFF, 16'hFFFF, 1'b0);
    queue_word(16'h8000, 8'h80, 16'h8000, 1'b1);
    // neighbours differing in one field, lower fields against higher ones
    queue_word(16'h8000, 8'h80, 16'h7FFF, 1'b0);
    queue_word(16'h8000, 8'h7F, 16'hFFFF, 1'b0);
    queue_word(16'h7FFF, 8'hFF, 16'hFFFF, 1'b0);
    queue_word(16'h8001, 8'h00, 16'h0000, 1'b0);
    queue_word(16'h0000, 8'h00, 16'h0001, 1'b0);
    queue_word(16'h0000, 8'h01, 16'h0000, 1'b0);
    queue_word(16'h0001, 8'h00, 16'h0000, 1'b0);
    queue_word(16'hFFFF, 8'hFF, 16'hFFFE, 1'b0);
    queue_word(16'hFFFF, 8'hFE, 16'hFFFF, 1'b0);
    queue_word(16'hAAAA, 8'h55, 16'h5555, 1'b0);
    queue_word(16'h5555, 8'hAA, 16'hAAAA, 1'b0);
    queue_word(16'h7FFF, 8'hFF, 16'hFFFF, 1'b0);
    queue_word(16'h8000, 8'h7F, 16'hFFFF, 1'b1);

    // fill the table, then keep it full with duplicates and rejected keys
    for (int unsigned n = 0; n < RandWords; n++) begin
      if ($urandom_range(0, 99) < 35) begin
        k = offered_keys[$urandom_range(0, offered_keys.size() - 1)];
        queue_word(k[KeyW-1 -: LineW], k[SentW +: OrderW], k[SentW-1:0], n % 200 == 199);
      end else begin
        queue_word(draw_line(), draw_order(), draw_sent(), n % 200 == 199);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d position words accepted, %0d result words checked", words_accepted,
             results_checked);
    $display("inserted %0d, duplicates %0d, rejected while full %0d", n_inserted,
             n_duplicate, n_full);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
